// File: sv/cvc_pkg.sv
// Shared constants, codes and request/result types for the CIGAR variant caller.
package cvc_pkg;

  localparam int READ_SIZE   = 32;
  localparam int OFF_W       = $clog2(READ_SIZE + 1);
  localparam int IDX_W       = $clog2(READ_SIZE);
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CMD_LD_REF = 2'd0;
  localparam logic [1:0] CMD_LD_ALT = 2'd1;
  localparam logic [1:0] CMD_CIGAR  = 2'd2;

  localparam logic [2:0] CIG_MATCH = 3'd0;
  localparam logic [2:0] CIG_INS   = 3'd1;
  localparam logic [2:0] CIG_DEL   = 3'd2;
  localparam logic [2:0] CIG_SOFT  = 3'd3;

  // decoded job codes carried through the queue
  localparam logic [2:0] OP_LD_REF = 3'd0;
  localparam logic [2:0] OP_LD_ALT = 3'd1;
  localparam logic [2:0] OP_MATCH  = 3'd2;
  localparam logic [2:0] OP_INS    = 3'd3;
  localparam logic [2:0] OP_DEL    = 3'd4;
  localparam logic [2:0] OP_SOFT   = 3'd5;
  localparam logic [2:0] OP_NOP    = 3'd6;

  localparam logic [1:0] KIND_SNV = 2'd0;
  localparam logic [1:0] KIND_INS = 2'd1;
  localparam logic [1:0] KIND_DEL = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  index;
    logic [7:0]  base;
    logic [2:0]  cigar_op;
    logic [15:0] cigar_len;
    logic [30:0] read_pos;
    logic        new_read;
  } req_t;

  typedef struct packed {
    logic [31:0] var_pos;
    logic [1:0]  kind;
    logic [7:0]  ref_char;
    logic        ref_char_valid;
    logic [7:0]  alt_char;
    logic        alt_char_valid;
    logic        variant_end;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  index;
    logic [7:0]  base;
    logic [15:0] len;
    logic [30:0] rpos;
    logic        nr;
  } job_t;

endpackage

// File: sv/cvc_front.sv
// Front end: takes requests and classifies them into jobs.
module cvc_front
  import cvc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic job_valid,
  input  logic job_ready,
  output job_t job
);

  logic [2:0] op;

  always_comb begin
    case (in_req.cmd)
      CMD_LD_REF: op = OP_LD_REF;
      CMD_LD_ALT: op = OP_LD_ALT;
      CMD_CIGAR: begin
        case (in_req.cigar_op)
          CIG_MATCH: op = OP_MATCH;
          CIG_INS:   op = OP_INS;
          CIG_DEL:   op = OP_DEL;
          CIG_SOFT:  op = OP_SOFT;
          default:   op = OP_NOP;
        endcase
      end
      default: op = OP_NOP;
    endcase
  end

  // unknown commands are taken and dropped; unknown ops still carry new_read
  logic drop;
  assign drop     = (in_req.cmd != CMD_LD_REF) && (in_req.cmd != CMD_LD_ALT) &&
                    (in_req.cmd != CMD_CIGAR);
  assign job_valid = in_valid && !drop;
  assign in_ready  = drop || job_ready;

  assign job.op    = op;
  assign job.index = in_req.index;
  assign job.base  = in_req.base;
  assign job.len   = in_req.cigar_len;
  assign job.rpos  = in_req.read_pos;
  assign job.nr    = in_req.new_read;

  logic seen;
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (in_valid && in_ready) begin
      seen <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && drop) |-> in_ready)
    else $error("dropped request not taken");

  assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_ready) |-> !in_ready)
    else $error("request taken while queue full");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !seen) |=> seen)
    else $error("request tracking lost");

endmodule

// File: sv/cvc_queue.sv
// Short job queue between the front and back ends.
module cvc_queue
  import cvc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);

  job_t              slots [QUEUE_DEPTH];
  logic [QCNT_W-1:0] count;
  logic [QPTR_W-1:0] wptr, rptr;
  logic              push, pop;

  assign wr_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = slots[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wptr  <= '0;
      rptr  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count != '0))
    else $error("queue count lost a push");

  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !pop)
    else $error("pop from empty queue");

endmodule

// File: sv/cvc_back.sv
// Back end: base stores, CIGAR step sequencer, result holding and output register.
module cvc_back
  import cvc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic [7:0] ref_mem [READ_SIZE];
  logic [7:0] alt_mem [READ_SIZE];

  logic [OFF_W-1:0] ref_offset, alt_offset;
  logic [OFF_W-1:0] ptr_r, ptr_a, cnt;
  logic [31:0]      pos;
  logic [2:0]       op_r;
  logic             first, ra0, aa0;

  // stage 2: registered store reads plus step info
  logic        s2_valid, s2_match, s2_rv, s2_av, s2_fin;
  logic [1:0]  s2_kind;
  logic [31:0] s2_pos;
  logic [7:0]  ref_rd, alt_rd;

  // pending result, held until we know whether it closes its request
  res_t p_res;
  res_t p_out;
  logic p_valid, p_done;

  logic take, issue, s2_free, s2_adv, s2_prod, p_move, o_free;
  logic [OFF_W-1:0] ro, ao, most, rem, span;
  logic             st_rv, st_av;
  res_t             r_new;

  assign job_ready = (cnt == '0);
  assign take      = job_valid && job_ready;

  always_comb begin
    ro   = job.nr ? '0 : ref_offset;
    ao   = job.nr ? '0 : alt_offset;
    most = (ro > ao) ? ro : ao;
    rem  = OFF_W'(READ_SIZE) - most;
    span = (job.len < 16'(rem)) ? job.len[OFF_W-1:0] : rem;
  end

  always_ff @(posedge clk) begin
    if (take && (job.op == OP_LD_REF) && (32'(job.index) < READ_SIZE)) begin
      ref_mem[IDX_W'(job.index)] <= job.base;
    end
    if (take && (job.op == OP_LD_ALT) && (32'(job.index) < READ_SIZE)) begin
      alt_mem[IDX_W'(job.index)] <= job.base;
    end
    if (issue) begin
      ref_rd <= ref_mem[ptr_r[IDX_W-1:0]];
      alt_rd <= alt_mem[ptr_a[IDX_W-1:0]];
    end
  end

  always_comb begin
    if (op_r == OP_MATCH) begin
      st_rv = 1'b1;
      st_av = 1'b1;
    end else if (first) begin
      st_rv = ra0;
      st_av = aa0;
    end else begin
      st_rv = (op_r == OP_DEL);
      st_av = (op_r == OP_INS);
    end
  end

  assign s2_free = !s2_valid || s2_adv;
  assign issue   = (cnt != '0) && s2_free;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      ref_offset <= '0;
      alt_offset <= '0;
    end else if (take) begin
      case (job.op)
        OP_MATCH: begin
          cnt        <= span;
          ref_offset <= ro + span;
          alt_offset <= ao + span;
        end
        OP_INS: begin
          cnt        <= span + 1'b1;
          ref_offset <= ro;
          alt_offset <= ao + span;
        end
        OP_DEL: begin
          cnt        <= span + 1'b1;
          ref_offset <= ro + span;
          alt_offset <= ao;
        end
        OP_SOFT: begin
          ref_offset <= ro;
          alt_offset <= ao + span;
        end
        OP_NOP: begin
          ref_offset <= ro;
          alt_offset <= ao;
        end
        default: begin
        end
      endcase
    end else if (issue) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r  <= job.op;
      first <= 1'b1;
      ra0   <= (ro != '0);
      aa0   <= (ao != '0);
      pos   <= {1'b0, job.rpos} + 32'(ro);
      ptr_r <= (job.op == OP_MATCH) ? ro : ro - 1'b1;
      ptr_a <= (job.op == OP_MATCH) ? ao : ao - 1'b1;
    end else if (issue) begin
      first <= 1'b0;
      ptr_r <= ptr_r + 1'b1;
      ptr_a <= ptr_a + 1'b1;
      if (op_r == OP_MATCH) begin
        pos <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (issue) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_match <= (op_r == OP_MATCH);
      s2_kind  <= (op_r == OP_MATCH) ? KIND_SNV :
                  (op_r == OP_INS) ? KIND_INS : KIND_DEL;
      s2_rv    <= st_rv;
      s2_av    <= st_av;
      s2_fin   <= (cnt == OFF_W'(1));
      s2_pos   <= pos;
    end
  end

  assign s2_prod = !s2_match || (ref_rd != alt_rd);

  always_comb begin
    r_new.var_pos        = s2_pos;
    r_new.kind           = s2_kind;
    r_new.ref_char       = s2_rv ? ref_rd : 8'd0;
    r_new.ref_char_valid = s2_rv;
    r_new.alt_char       = s2_av ? alt_rd : 8'd0;
    r_new.alt_char_valid = s2_av;
    r_new.variant_end    = s2_match || s2_fin;
    r_new.last           = 1'b0;
  end

  assign o_free = !out_valid || out_ready;
  assign p_move = p_valid && o_free && (p_done || (s2_valid && s2_prod));
  assign s2_adv = s2_valid && (!s2_prod || !p_valid || p_move);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_done  <= 1'b0;
    end else if (s2_adv && s2_prod) begin
      p_valid <= 1'b1;
      p_done  <= s2_fin;
    end else if (p_move) begin
      p_valid <= 1'b0;
      p_done  <= 1'b0;
    end else if (s2_adv && s2_fin && p_valid) begin
      p_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_prod) begin
      p_res <= r_new;
    end
  end

  always_comb begin
    p_out      = p_res;
    p_out.last = p_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      out_res <= p_out;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (ref_offset <= OFF_W'(READ_SIZE)) && (alt_offset <= OFF_W'(READ_SIZE)))
    else $error("offset beyond read size");

  assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_adv) |=> (s2_valid && $stable(s2_pos)))
    else $error("stalled step lost");

  assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> !take)
    else $error("job taken while stepping");

  assert property (@(posedge clk) disable iff (rst)
    p_move |-> o_free)
    else $error("output overwritten");

endmodule

// File: sv/cigar_variant_caller_unit.sv
// Top level of the CIGAR variant caller.
// Requests either load one reference or read base into a 32-entry store, or carry
// one CIGAR entry. Every request is taken into a two-entry queue when it has room,
// or dropped at once when its command is unknown; the back end then handles it. A
// CIGAR entry, with its length clamped so that neither offset passes the read
// size, is stepped one base pair at a time for a match and one character pair at
// a time for an insertion or deletion (clamped length plus one pairs), paced by
// the single read port of each base store; no new job is taken until all steps
// are issued. Soft clip, hard clip and unknown ops give no steps. Output stalls
// hold the steps once the result path is full. Matches give one result per
// mismatching pair; an indel gives one result per character pair,
// anchored on the preceding base, whose character is marked invalid when that
// offset is zero. A result is held back one step so that last can be set on the
// final result of its request. The base stores have no reset: reading an entry
// never loaded gives an undefined character.
module cigar_variant_caller_unit
  import cvc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  // front end to queue
  logic f_valid, f_ready;
  job_t f_job;

  // queue to back end
  logic q_valid, q_ready;
  job_t q_job;

  cvc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  cvc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_job   (f_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_job   (q_job)
  );

  cvc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the CIGAR variant caller unit.
`timescale 1ns / 100ps

module testbench;
  import cvc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_res;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cigar_variant_caller_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(out_res)
  );

  // Model copy of the stores and the two offsets.
  logic [7:0] ref_bases [READ_SIZE];
  logic [7:0] read_bases [READ_SIZE];
  int unsigned ref_off, read_off;

  res_t variants_due [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_starts = 0;
  int hold_seen = 0;
  int hold_off = 0;

  task automatic report(input string what, input res_t got, input res_t want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic res_t make_var(input logic [31:0] pos, input logic [1:0] k,
                                    input logic [7:0] rc, input bit rv,
                                    input logic [7:0] ac, input bit av, input bit ve);
    res_t r;
    r.var_pos = pos;
    r.kind = k;
    r.ref_char = rv ? rc : 8'd0;
    r.ref_char_valid = rv;
    r.alt_char = av ? ac : 8'd0;
    r.alt_char_valid = av;
    r.variant_end = ve;
    r.last = 1'b0;
    return r;
  endfunction

  // Works out the variants one request yields and queues them.
  task automatic call_variants(input req_t q);
    int unsigned most, span, n0;
    logic [31:0] pos;
    bit ins, ra, aa;
    logic [7:0] rc0, ac0;
    n0 = variants_due.size();
    if (q.cmd == CMD_LD_REF) begin
      ref_bases[q.index] = q.base;
      return;
    end
    if (q.cmd == CMD_LD_ALT) begin
      read_bases[q.index] = q.base;
      return;
    end
    if (q.cmd != CMD_CIGAR) return;
    if (q.new_read) begin
      ref_off = 0; read_off = 0;
    end
    most = ref_off > read_off ? ref_off : read_off;
    span = READ_SIZE - most;
    if (q.cigar_len < span) span = q.cigar_len;
    case (q.cigar_op)
      CIG_MATCH: begin
        for (int i = 0; i < span; i++)
          if (ref_bases[IDX_W'(ref_off + i)] != read_bases[IDX_W'(read_off + i)])
            variants_due.push_back(make_var(q.read_pos + ref_off + i, KIND_SNV,
              ref_bases[IDX_W'(ref_off + i)], 1, read_bases[IDX_W'(read_off + i)], 1, 1));
        ref_off += span; read_off += span;
      end
      CIG_INS, CIG_DEL: begin
        ins = (q.cigar_op == CIG_INS);
        ra = ref_off > 0; aa = read_off > 0;
        rc0 = ra ? ref_bases[IDX_W'(ref_off - 1)] : 8'd0;
        ac0 = aa ? read_bases[IDX_W'(read_off - 1)] : 8'd0;
        pos = q.read_pos + ref_off;
        for (int i = 0; i <= span; i++) begin
          if (i == 0)
            variants_due.push_back(make_var(pos, ins ? KIND_INS : KIND_DEL,
              rc0, ra, ac0, aa, i == span));
          else if (ins)
            variants_due.push_back(make_var(pos, KIND_INS, 0, 0,
              read_bases[IDX_W'(read_off - 1 + i)], 1, i == span));
          else
            variants_due.push_back(make_var(pos, KIND_DEL,
              ref_bases[IDX_W'(ref_off - 1 + i)], 1, 0, 0, i == span));
        end
        if (ins) read_off += span; else ref_off += span;
      end
      CIG_SOFT: read_off += span;
      default: ;
    endcase
    if (variants_due.size() > n0) variants_due[$].last = 1'b1;
  endtask

  // Sends one request, with a random gap ahead of it.
  task automatic send(input req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    call_variants(q);
  endtask

  // Checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (variants_due.size() == 0)
        report("unexpected", out_res, '0);
      else if (out_res !== variants_due[0]) begin
        report("variant", out_res, variants_due[0]);
        void'(variants_due.pop_front());
      end else
        void'(variants_due.pop_front());
    end
  end

  // Receiver side: random stalls, plus a counted long hold-off.
  always @(posedge clk) begin
    if (hold_starts != hold_seen) begin
      hold_seen <= hold_starts;
      hold_off <= 300;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic req_t load_req(input logic [1:0] c, input logic [4:0] i,
                                    input logic [7:0] b);
    req_t q = '0;
    q.cmd = c; q.index = i; q.base = b;
    q.cigar_op = 3'($urandom); q.cigar_len = 16'($urandom);
    q.read_pos = 31'($urandom);
    q.new_read = 1'($urandom);
    return q;
  endfunction

  function automatic req_t cigar_req(input logic [2:0] op, input logic [15:0] len,
                                     input logic [30:0] pos, input bit nr);
    req_t q = '0;
    q.cmd = CMD_CIGAR; q.cigar_op = op; q.cigar_len = len;
    q.read_pos = pos; q.new_read = nr;
    q.index = 5'($urandom); q.base = 8'($urandom);
    return q;
  endfunction

  // Fills both stores; unless noisy, similar contents so matches give few SNVs.
  task automatic fill_stores(input bit noisy);
    logic [7:0] b;
    for (int i = 0; i < READ_SIZE; i++) begin
      b = 8'($urandom);
      send(load_req(CMD_LD_REF, 5'(i), b));
      send(load_req(CMD_LD_ALT, 5'(i),
        (noisy || $urandom_range(3) == 0) ? 8'($urandom) : b));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (variants_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic test_directed();
    send(load_req(CMD_LD_REF, 0, 8'hFF));
    send(load_req(CMD_LD_ALT, 0, 8'h00));
    fill_stores(1);
    send(load_req(2'd3, 5, 8'hAA));                         // unknown command
    send(cigar_req(CIG_INS, 3, 31'h7FFFFFFF, 1));            // indel at offset zero
    send(cigar_req(CIG_DEL, 2, 0, 1));
    send(cigar_req(CIG_MATCH, 16'hFFFF, 31'h7FFFFFFF, 1));   // clamped, full read
    send(cigar_req(CIG_INS, 5, 100, 0));                     // clamped to zero
    send(cigar_req(CIG_SOFT, 4, 0, 1));
    send(cigar_req(CIG_MATCH, 0, 7, 0));
    send(cigar_req(CIG_DEL, 16'hFFFF, 7, 0));               // clamped deletion
    send(cigar_req(3'd4, 9, 7, 0));                          // hard clip
    send(cigar_req(3'd7, 9, 7, 1));                          // unknown op, clear
    send(cigar_req(CIG_INS, 16'hFFFF, 55, 0));               // longest insertion
    send(cigar_req(3'd5, 1, 0, 0));
    send(cigar_req(CIG_MATCH, 10, 3, 1));
    send(cigar_req(CIG_INS, 2, 3, 0));
  endtask

  // Mostly well-formed reads: fresh start, then a run of CIGAR entries.
  task automatic test_random(input int n);
    int sent = 0;
    logic [30:0] pos;
    req_t q;
    while (sent < n) begin
      pos = 31'($urandom);
      q = cigar_req(3'($urandom_range(4)), 16'($urandom_range(12)), pos, 1);
      send(q); sent++;
      repeat ($urandom_range(6)) begin
        case ($urandom_range(9))
          0: q = cigar_req(3'($urandom_range(7)), 16'($urandom), pos, 1'($urandom));
          1: q = load_req(2'd3, 5'($urandom), 8'($urandom));
          2: q = load_req(2'($urandom_range(1)), 5'($urandom), 8'($urandom));
          default: q = cigar_req(3'($urandom_range(4)), 16'($urandom_range(10)), pos, 0);
        endcase
        send(q); sent++;
      end
    end
  endtask

  // Long receiver hold-off while deletions keep coming, so the input stalls.
  task automatic test_back_pressure();
    hold_starts++;
    for (int i = 0; i < 6; i++)
      send(cigar_req(CIG_DEL, 4, 31'(9 + i), 1));
    test_random(6);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 0; recv_stall_pct = 0;
    fill_stores(0);
    test_random(10);
    wait_drained();                  // sender pauses until all is out
    send_idle_pct = 67; recv_stall_pct = 0;
    test_random(10);
    send_idle_pct = 0; recv_stall_pct = 67;
    test_random(10);
    send_idle_pct = 6; recv_stall_pct = 6;
    test_back_pressure();
    test_random(10);
    wait_drained();
    if (errors == 0 && variants_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
sv/cvc_pkg.sv
sv/cvc_front.sv
sv/cvc_queue.sv
sv/cvc_back.sv
sv/cigar_variant_caller_unit.sv
sim/testbench.sv
